>>> src/cpr_pkg.sv
// Package for the closest point on rectangle block: widths, types, helpers.
// No dependencies; used by every file in src.
package cpr_pkg;

  localparam int CoordBits = 16;
  localparam int DiffBits  = CoordBits + 1;
  localparam int SqBits    = 2 * DiffBits;
  localparam int DistBits  = SqBits + 1;
  localparam int DotBits   = DistBits + 1;
  localparam int MagBits   = DiffBits;
  localparam int ProdBits  = MagBits + DistBits;
  localparam int QuotBits  = MagBits;
  localparam int DivSteps  = QuotBits;
  localparam int IdxBits   = 2;
  // two modes, four signs, start, two ends and the query point
  localparam int TagBits   = 2 * 2 + 4 + 4 * 2 * CoordBits;

  typedef logic signed [CoordBits-1:0] coord_t;
  typedef logic signed [DiffBits-1:0]  diff_t;
  typedef logic        [DistBits-1:0]  dist_t;
  typedef logic signed [DotBits-1:0]   dot_t;
  typedef logic        [ProdBits-1:0]  prod_t;
  typedef logic        [QuotBits-1:0]  quot_t;
  typedef logic        [TagBits-1:0]   tag_t;

  typedef enum logic [1:0] {
    VTX_A = 2'd0,
    VTX_B = 2'd1,
    VTX_C = 2'd2,
    VTX_D = 2'd3
  } vtx_e;

  typedef enum logic [1:0] {
    MODE_START = 2'd0,
    MODE_END   = 2'd1,
    MODE_INNER = 2'd2
  } mode_e;

  typedef struct packed {
    coord_t x;
    coord_t y;
  } point_t;

  // Edge direction or point
  function automatic diff_t sub_c(coord_t a, coord_t b);
    sub_c = diff_t'(a) - diff_t'(b);
  endfunction

  function automatic dist_t sq_d(diff_t dx, diff_t dy);
    logic signed [SqBits-1:0] px;
    logic signed [SqBits-1:0] py;
    px = dx * dx;
    py = dy * dy;
    sq_d = dist_t'(px) + dist_t'(py);
  endfunction

  function automatic vtx_e nbr_first(vtx_e k);
    unique case (k)
      VTX_A:   nbr_first = VTX_B;
      VTX_B:   nbr_first = VTX_A;
      VTX_C:   nbr_first = VTX_B;
      default: nbr_first = VTX_C;
    endcase
  endfunction

  function automatic vtx_e nbr_second(vtx_e k);
    unique case (k)
      VTX_A:   nbr_second = VTX_D;
      VTX_B:   nbr_second = VTX_C;
      VTX_C:   nbr_second = VTX_D;
      default: nbr_second = VTX_A;
    endcase
  endfunction

endpackage

>>> src/cpr_if.sv
// Valid/ready channel interfaces for query beats and result beats.
// Depends on cpr_pkg.
interface cpr_query_if;
  logic            valid;
  logic            ready;
  cpr_pkg::coord_t vertex_a_x;
  cpr_pkg::coord_t vertex_a_y;
  cpr_pkg::coord_t vertex_b_x;
  cpr_pkg::coord_t vertex_b_y;
  cpr_pkg::coord_t vertex_c_x;
  cpr_pkg::coord_t vertex_c_y;
  cpr_pkg::coord_t vertex_d_x;
  cpr_pkg::coord_t vertex_d_y;
  cpr_pkg::coord_t query_x;
  cpr_pkg::coord_t query_y;
  modport source (output valid, vertex_a_x, vertex_a_y, vertex_b_x, vertex_b_y,
                  vertex_c_x, vertex_c_y, vertex_d_x, vertex_d_y, query_x, query_y,
                  input ready);
  modport sink (input valid, vertex_a_x, vertex_a_y, vertex_b_x, vertex_b_y,
                vertex_c_x, vertex_c_y, vertex_d_x, vertex_d_y, query_x, query_y,
                output ready);
endinterface

interface cpr_result_if;
  logic            valid;
  logic            ready;
  cpr_pkg::coord_t nearest_x;
  cpr_pkg::coord_t nearest_y;
  modport source (output valid, nearest_x, nearest_y, input ready);
  modport sink (input valid, nearest_x, nearest_y, output ready);
endinterface

>>> src/cpr_edge_setup.sv
// Edge setup stage: edge vector, squared length and dot product of one edge.
// Depends on cpr_pkg. Two register stages.
module cpr_edge_setup (
  input  logic            clk_i,
  input  logic            en_i,
  input  cpr_pkg::point_t start_i,
  input  cpr_pkg::point_t end_i,
  input  cpr_pkg::point_t query_i,
  output cpr_pkg::diff_t  ex_o,
  output cpr_pkg::diff_t  ey_o,
  output cpr_pkg::dist_t  len2_o,
  output cpr_pkg::dot_t   dot_o
);
  import cpr_pkg::*;

  diff_t ex_q, ey_q, rx_q, ry_q;
  diff_t ex2_q, ey2_q;
  logic signed [SqBits-1:0] dx_q, dy_q;
  dist_t len2_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      ex_q  <= sub_c(end_i.x, start_i.x);
      ey_q  <= sub_c(end_i.y, start_i.y);
      rx_q  <= sub_c(query_i.x, start_i.x);
      ry_q  <= sub_c(query_i.y, start_i.y);
      dx_q  <= rx_q * ex_q;
      dy_q  <= ry_q * ey_q;
      len2_q <= sq_d(ex_q, ey_q);
      ex2_q <= ex_q;
      ey2_q <= ey_q;
    end
  end

  assign ex_o   = ex2_q;
  assign ey_o   = ey2_q;
  assign len2_o = len2_q;
  assign dot_o  = DotBits'(dx_q) + DotBits'(dy_q);
endmodule

>>> src/cpr_div.sv
// Pipelined restoring divider: one quotient bit per stage.
// Depends on cpr_pkg. Carries a tag alongside the quotient.
module cpr_div (
  input  logic           clk_i,
  input  logic           en_i,
  input  cpr_pkg::prod_t num_i,
  input  cpr_pkg::dist_t den_i,
  input  cpr_pkg::tag_t  tag_i,
  output cpr_pkg::quot_t quot_o,
  output cpr_pkg::tag_t  tag_o
);
  import cpr_pkg::*;

  localparam int RemBits = DistBits + 1;

  prod_t              num_q [1:DivSteps];
  logic [RemBits-1:0] rem_q [1:DivSteps];
  dist_t              den_q [1:DivSteps];
  quot_t              quo_q [1:DivSteps];
  tag_t               tag_q [1:DivSteps];

  for (genvar s = 0; s < DivSteps; s++) begin : g_step
    prod_t              num_in;
    logic [RemBits-1:0] rem_in;
    dist_t              den_in;
    quot_t              quo_in;
    tag_t               tag_in;
    logic [RemBits-1:0] trial;
    logic [RemBits-1:0] sub;
    if (s == 0) begin : g_head
      assign num_in = num_i;
      assign rem_in = RemBits'(num_i >> QuotBits);
      assign den_in = den_i;
      assign quo_in = '0;
      assign tag_in = tag_i;
    end else begin : g_body
      assign num_in = num_q[s];
      assign rem_in = rem_q[s];
      assign den_in = den_q[s];
      assign quo_in = quo_q[s];
      assign tag_in = tag_q[s];
    end
    always_comb begin
      trial = {rem_in[RemBits-2:0], num_in[QuotBits-1-s]};
      sub   = trial - RemBits'(den_in);
    end
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        num_q[s+1] <= num_in;
        den_q[s+1] <= den_in;
        tag_q[s+1] <= tag_in;
        if (trial >= RemBits'(den_in)) begin
          rem_q[s+1] <= sub;
          quo_q[s+1] <= quo_in | (quot_t'(1) << (QuotBits-1-s));
        end else begin
          rem_q[s+1] <= trial;
          quo_q[s+1] <= quo_in;
        end
      end
    end
  end

  assign quot_o = quo_q[DivSteps];
  assign tag_o  = tag_q[DivSteps];
endmodule

>>> src/closest_point_on_rectangle.sv
// Closest point on a rectangle perimeter, pipelined; one query beat per cycle.
// A query beat is taken every cycle while the result side keeps up; each beat
// yields one result beat, the pipe depth being set by the
// one-bit-per-stage projection dividers. The whole pipe stalls together only
// when the two-entry skid buffer at the output is full and a result waits at
// the last stage, so the query ready never depends on the result ready.
// Depends on cpr_pkg, cpr_if, cpr_edge_setup and cpr_div.
module closest_point_on_rectangle (
  input  logic      clk_i,
  input  logic      rst_ni,
  cpr_query_if.sink   in_i,
  cpr_result_if.source out_o
);
  import cpr_pkg::*;

  localparam int Lat = DivSteps + 10;
  // stage layout: s1 vertex dist, s2 pick, s3..s4 edge setup, s5 clamp/num,
  // divider, then add, sub, mul, sum, select

  logic en;
  logic [Lat-1:0] vld_q;

  // skid buffer
  point_t sk_data_q [2];
  logic [1:0] sk_cnt_q;
  logic sk_wr_ptr_q, sk_rd_ptr_q;

  assign en = (sk_cnt_q != 2'd2) || !vld_q[Lat-1];
  assign in_i.ready = en;

  // stage 1: vertex distances
  point_t v_q [4];
  point_t p_q;
  dist_t  vd_q [4];
  point_t vin [4];
  always_comb begin
    vin[0] = '{in_i.vertex_a_x, in_i.vertex_a_y};
    vin[1] = '{in_i.vertex_b_x, in_i.vertex_b_y};
    vin[2] = '{in_i.vertex_c_x, in_i.vertex_c_y};
    vin[3] = '{in_i.vertex_d_x, in_i.vertex_d_y};
  end
  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int i = 0; i < 4; i++) begin
        v_q[i]  <= vin[i];
        vd_q[i] <= sq_d(sub_c(vin[i].x, in_i.query_x), sub_c(vin[i].y, in_i.query_y));
      end
      p_q <= '{in_i.query_x, in_i.query_y};
    end
  end

  // stage 2: pick nearest vertex and its edges
  vtx_e   k;
  point_t s2_st_q, s2_e1_q, s2_e2_q, s2_p_q;
  always_comb begin
    dist_t b;
    b = vd_q[0];
    k = VTX_A;
    if (vd_q[1] < b) begin b = vd_q[1]; k = VTX_B; end
    if (vd_q[2] < b) begin b = vd_q[2]; k = VTX_C; end
    if (vd_q[3] < b) begin k = VTX_D; end
  end
  always_ff @(posedge clk_i) begin
    if (en) begin
      s2_st_q <= v_q[k];
      s2_e1_q <= v_q[nbr_first(k)];
      s2_e2_q <= v_q[nbr_second(k)];
      s2_p_q  <= p_q;
    end
  end

  // stages 3-4: edge setup
  diff_t ex [2], ey [2];
  dist_t len2 [2];
  dot_t  dot [2];
  cpr_edge_setup u_es1 (.clk_i, .en_i(en), .start_i(s2_st_q), .end_i(s2_e1_q),
    .query_i(s2_p_q), .ex_o(ex[0]), .ey_o(ey[0]), .len2_o(len2[0]), .dot_o(dot[0]));
  cpr_edge_setup u_es2 (.clk_i, .en_i(en), .start_i(s2_st_q), .end_i(s2_e2_q),
    .query_i(s2_p_q), .ex_o(ex[1]), .ey_o(ey[1]), .len2_o(len2[1]), .dot_o(dot[1]));

  point_t s3_st_q, s3_e1_q, s3_e2_q, s3_p_q;
  point_t s4_st_q, s4_e1_q, s4_e2_q, s4_p_q;
  always_ff @(posedge clk_i) begin
    if (en) begin
      s3_st_q <= s2_st_q; s3_e1_q <= s2_e1_q; s3_e2_q <= s2_e2_q; s3_p_q <= s2_p_q;
      s4_st_q <= s3_st_q; s4_e1_q <= s3_e1_q; s4_e2_q <= s3_e2_q; s4_p_q <= s3_p_q;
    end
  end

  // stage 5: classify and form numerators (start, end or interior point)
  mode_e mode [2];
  logic [3:0] sgn;
  prod_t num_d [4];
  dist_t den_d [2];
  always_comb begin
    for (int e = 0; e < 2; e++) begin
      dist_t dmag;
      dmag = dist_t'(dot[e]);
      if (len2[e] == '0 || dot[e] <= 0) mode[e] = MODE_START;
      else if (dmag >= len2[e]) mode[e] = MODE_END;
      else mode[e] = MODE_INNER;
      num_d[2*e]   = prod_t'(MagBits'(ex[e] < 0 ? -ex[e] : ex[e])) * prod_t'(dmag);
      num_d[2*e+1] = prod_t'(MagBits'(ey[e] < 0 ? -ey[e] : ey[e])) * prod_t'(dmag);
      sgn[2*e]   = ex[e][DiffBits-1];
      sgn[2*e+1] = ey[e][DiffBits-1];
      den_d[e] = (len2[e] == '0) ? dist_t'(1) : len2[e];
    end
  end

  prod_t num_q [4];
  dist_t den_q [2];
  tag_t  tag_q;
  always_ff @(posedge clk_i) begin
    if (en) begin
      num_q <= num_d;
      den_q <= den_d;
      tag_q <= {mode[0], mode[1], sgn, s4_st_q, s4_e1_q, s4_e2_q, s4_p_q};
    end
  end

  quot_t quo [4];
  tag_t  div_tag [4];
  for (genvar j = 0; j < 4; j++) begin : g_div
    cpr_div u_div (.clk_i, .en_i(en), .num_i(num_q[j]),
      .den_i(den_q[j/2]), .tag_i(tag_q), .quot_o(quo[j]), .tag_o(div_tag[j]));
  end

  // stage: form projected points
  logic [1:0] m0, m1;
  logic [3:0] sg;
  point_t st, e1, e2, pp;
  point_t c_d [2];
  assign {m0, m1, sg, st, e1, e2, pp} = div_tag[0];
  always_comb begin
    point_t en_p [2];
    logic [1:0] mm [2];
    en_p[0] = e1; en_p[1] = e2;
    mm[0] = m0; mm[1] = m1;
    for (int e = 0; e < 2; e++) begin
      diff_t qx, qy;
      qx = sg[2*e]   ? -diff_t'(quo[2*e])   : diff_t'(quo[2*e]);
      qy = sg[2*e+1] ? -diff_t'(quo[2*e+1]) : diff_t'(quo[2*e+1]);
      if (mm[e] == MODE_START) c_d[e] = st;
      else if (mm[e] == MODE_END) c_d[e] = en_p[e];
      else c_d[e] = '{coord_t'(diff_t'(st.x) + qx), coord_t'(diff_t'(st.y) + qy)};
    end
  end

  point_t c_q [2], c2_q [2], c3_q [2], pp_q;
  diff_t dx_q [2], dy_q [2];
  logic signed [SqBits-1:0] sx_q [2], sy_q [2];
  dist_t d_q [2];
  point_t res_q;
  always_ff @(posedge clk_i) begin
    if (en) begin
      c_q <= c_d; pp_q <= pp;
      for (int e = 0; e < 2; e++) begin
        dx_q[e] <= sub_c(c_q[e].x, pp_q.x);
        dy_q[e] <= sub_c(c_q[e].y, pp_q.y);
        sx_q[e] <= dx_q[e] * dx_q[e];
        sy_q[e] <= dy_q[e] * dy_q[e];
        d_q[e]  <= dist_t'(sx_q[e]) + dist_t'(sy_q[e]);
      end
      c2_q <= c_q; c3_q <= c2_q;
    end
  end
  point_t c4_q [2];
  always_ff @(posedge clk_i) begin
    if (en) begin
      c4_q <= c3_q;
      res_q <= (d_q[0] <= d_q[1]) ? c4_q[0] : c4_q[1];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en) begin
      vld_q <= {vld_q[Lat-2:0], in_i.valid};
    end
  end

  // skid buffer
  logic push, pop;
  assign push = en && vld_q[Lat-1];
  assign pop  = out_o.valid && out_o.ready;
  always_ff @(posedge clk_i) begin
    if (push) sk_data_q[sk_wr_ptr_q] <= res_q;
  end
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sk_cnt_q <= '0; sk_wr_ptr_q <= 1'b0; sk_rd_ptr_q <= 1'b0;
    end else begin
      if (push) sk_wr_ptr_q <= !sk_wr_ptr_q;
      if (pop)  sk_rd_ptr_q <= !sk_rd_ptr_q;
      sk_cnt_q <= sk_cnt_q + 2'(push) - 2'(pop);
    end
  end

  assign out_o.valid     = sk_cnt_q != 2'd0;
  assign out_o.nearest_x = sk_data_q[sk_rd_ptr_q].x;
  assign out_o.nearest_y = sk_data_q[sk_rd_ptr_q].y;

`ifndef SYNTHESIS
  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(push && !pop && sk_cnt_q == 2'd2)) else $error("skid overflow");
  a_cnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    sk_cnt_q != 2'd3) else $error("skid count");
  a_stall_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !en |=> $stable(vld_q)) else $error("pipe moved on stall");
`endif
endmodule

>>> dv/tb_closest_point_on_rectangle.sv
// Testbench for closest_point_on_rectangle: random and directed query beats,
// a bit-exact result predictor, and a checker on the result channel.
// Depends on cpr_pkg, cpr_if and the RTL in src.
`timescale 1ns / 1ps

module tb_closest_point_on_rectangle;
  import cpr_pkg::*;

  typedef struct packed {
    coord_t ax, ay, bx, by, cx, cy, dx, dy, qx, qy;
  } query_t;

  localparam int WatchdogLimit = 20000;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  cpr_query_if  qry ();
  cpr_result_if res ();

  closest_point_on_rectangle DUT (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (qry.sink),
    .out_o  (res.source)
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  query_t pending_q[$];
  point_t nearest_q[$];
  int     errors = 0;
  int     burst_left = 0;
  int     gap_left = 0;
  int     hold_off = 0;
  int     rcv_count = 0;
  bit     long_done = 1'b0;
  bit     stim_done = 1'b0;
  bit     drain_pause = 1'b0;
  int     idle_cycles = 0;

  function automatic longint sq(longint ux, longint uy, longint vx, longint vy);
    return (vx - ux) * (vx - ux) + (vy - uy) * (vy - uy);
  endfunction

  // Distances fit 34 bits; e * dot fits 17 + 36 bits, within 64.
  function automatic point_t project_edge(longint sx, longint sy, longint ex_, longint ey_,
                                          longint px, longint py);
    longint ex, ey, len2, dotp;
    point_t r;
    ex = ex_ - sx;
    ey = ey_ - sy;
    len2 = ex * ex + ey * ey;
    dotp = (px - sx) * ex + (py - sy) * ey;
    if (len2 == 0 || dotp <= 0) begin
      r.x = coord_t'(sx);
      r.y = coord_t'(sy);
    end else if (dotp >= len2) begin
      r.x = coord_t'(ex_);
      r.y = coord_t'(ey_);
    end else begin
      r.x = coord_t'(sx + (ex * dotp) / len2);
      r.y = coord_t'(sy + (ey * dotp) / len2);
    end
    return r;
  endfunction

  function automatic point_t nearest_point(query_t q);
    longint vx[4], vy[4], px, py, best, d, d1, d2;
    int     k, n1, n2;
    point_t p1, p2;
    vx[0] = q.ax; vy[0] = q.ay; vx[1] = q.bx; vy[1] = q.by;
    vx[2] = q.cx; vy[2] = q.cy; vx[3] = q.dx; vy[3] = q.dy;
    px = q.qx; py = q.qy;
    k = 0;
    best = sq(px, py, vx[0], vy[0]);
    for (int i = 1; i < 4; i++) begin
      d = sq(px, py, vx[i], vy[i]);
      if (d < best) begin
        best = d;
        k = i;
      end
    end
    case (k)
      0: begin n1 = 1; n2 = 3; end
      1: begin n1 = 0; n2 = 2; end
      2: begin n1 = 1; n2 = 3; end
      default: begin n1 = 2; n2 = 0; end
    endcase
    p1 = project_edge(vx[k], vy[k], vx[n1], vy[n1], px, py);
    p2 = project_edge(vx[k], vy[k], vx[n2], vy[n2], px, py);
    d1 = sq(px, py, p1.x, p1.y);
    d2 = sq(px, py, p2.x, p2.y);
    return (d1 <= d2) ? p1 : p2;
  endfunction

  task automatic report_mismatch(string what, int got, int want);
    $display("mismatch %s: got %0d expected %0d", what, got, want);
    errors++;
  endtask

  function automatic coord_t rnd_coord(int mode);
    case (mode)
      0: return coord_t'($urandom);
      1: return coord_t'($urandom_range(0, 255) - 128);
      default: return coord_t'($urandom_range(0, 2047) - 1024);
    endcase
  endfunction

  function automatic query_t rect_query();
    query_t q;
    int     mode, cx, cy, ux, uy, s, ox, oy;
    mode = $urandom_range(0, 2);
    if ($urandom_range(0, 9) == 0) begin
      q = query_t'({$urandom, $urandom, $urandom, $urandom, $urandom});
      return q;
    end
    cx = $urandom_range(0, 8000) - 4000;
    cy = $urandom_range(0, 8000) - 4000;
    ux = $urandom_range(0, 600) - 300;
    uy = $urandom_range(0, 600) - 300;
    s = $urandom_range(0, 3);
    ox = -uy * s / 2;
    oy = ux * s / 2;
    q.ax = coord_t'(cx - ux - ox); q.ay = coord_t'(cy - uy - oy);
    q.bx = coord_t'(cx + ux - ox); q.by = coord_t'(cy + uy - oy);
    q.cx = coord_t'(cx + ux + ox); q.cy = coord_t'(cy + uy + oy);
    q.dx = coord_t'(cx - ux + ox); q.dy = coord_t'(cy - uy + oy);
    if (mode == 0) begin
      q.qx = coord_t'($urandom);
      q.qy = coord_t'($urandom);
    end else begin
      q.qx = coord_t'(cx + rnd_coord(mode));
      q.qy = coord_t'(cy + rnd_coord(mode));
    end
    return q;
  endfunction

  always @(posedge clk_i) begin
    if (!rst_ni) begin
      qry.valid <= 1'b0;
    end else begin
      if (qry.valid && qry.ready) begin
        nearest_q.push_back(nearest_point(pending_q.pop_front()));
      end
      if (!qry.valid || qry.ready) begin
        if (gap_left > 0 || drain_pause) begin
          if (gap_left > 0) gap_left <= gap_left - 1;
          qry.valid <= 1'b0;
        end else if (pending_q.size() > 0) begin
          qry.valid <= 1'b1;
          {qry.vertex_a_x, qry.vertex_a_y, qry.vertex_b_x, qry.vertex_b_y,
           qry.vertex_c_x, qry.vertex_c_y, qry.vertex_d_x, qry.vertex_d_y,
           qry.query_x, qry.query_y} <= pending_q[0];
          if (burst_left > 0) burst_left <= burst_left - 1;
          else begin
            burst_left <= $urandom_range(0, 30);
            gap_left <= ($urandom_range(0, 3) == 0) ? $urandom_range(1, 6) : 0;
          end
        end else begin
          qry.valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    point_t e;
    if (res.valid && res.ready) begin
      rcv_count <= rcv_count + 1;
      if (nearest_q.size() == 0) begin
        report_mismatch("unexpected beat", 0, 0);
      end else begin
        e = nearest_q.pop_front();
        if (res.nearest_x !== e.x) report_mismatch("nearest_x", res.nearest_x, e.x);
        if (res.nearest_y !== e.y) report_mismatch("nearest_y", res.nearest_y, e.y);
      end
    end
    if (hold_off > 0) begin
      hold_off <= hold_off - 1;
      res.ready <= 1'b0;
    end else if (!long_done && !stim_done && rcv_count >= 300) begin
      hold_off <= 200;
      long_done <= 1'b1;
      res.ready <= 1'b0;
    end else begin
      res.ready <= (($urandom >> 4) % 512 < 256) ? ($urandom_range(0, 3) != 0) : 1'b1;
    end
  end

  always @(posedge clk_i) begin
    if ((qry.valid && qry.ready) || (res.valid && res.ready) || !rst_ni) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WatchdogLimit) begin
      $display("status: fail");
      $finish;
    end
  end

  query_t q;
  initial begin
    qry.valid = 1'b0;
    res.ready = 1'b0;
    {qry.vertex_a_x, qry.vertex_a_y, qry.vertex_b_x, qry.vertex_b_y, qry.vertex_c_x,
     qry.vertex_c_y, qry.vertex_d_x, qry.vertex_d_y, qry.query_x, qry.query_y} = '0;
    q = '0;
    pending_q.push_back(q);
    pending_q.push_back(query_t'({10{16'sh7fff}}));
    pending_q.push_back(query_t'({10{16'sh8000}}));
    pending_q.push_back(query_t'({16'sh8000, 16'sh8000, 16'sh7fff, 16'sh8000, 16'sh7fff,
                                  16'sh7fff, 16'sh8000, 16'sh7fff, 16'sh0000, 16'sh0000}));
    pending_q.push_back(query_t'({16'sh8000, 16'sh8000, 16'sh7fff, 16'sh8000, 16'sh7fff,
                                  16'sh7fff, 16'sh8000, 16'sh7fff, 16'sh7fff, 16'sh8000}));
    pending_q.push_back(query_t'({16'sh8000, 16'sh8000, 16'sh7fff, 16'sh7fff, 16'sh8000,
                                  16'sh8000, 16'sh7fff, 16'sh7fff, 16'sh7fff, 16'sh8000}));
    // tie between vertices, tie between edges, point at corner, degenerate edges
    pending_q.push_back(query_t'({16'sd0, 16'sd0, 16'sd160, 16'sd0, 16'sd160, 16'sd160,
                                  16'sd0, 16'sd160, 16'sd80, 16'sd80}));
    pending_q.push_back(query_t'({16'sd0, 16'sd0, 16'sd160, 16'sd0, 16'sd160, 16'sd160,
                                  16'sd0, 16'sd160, 16'sd20, 16'sd20}));
    pending_q.push_back(query_t'({16'sd0, 16'sd0, 16'sd160, 16'sd0, 16'sd160, 16'sd160,
                                  16'sd0, 16'sd160, -16'sd30, -16'sd30}));
    pending_q.push_back(query_t'({16'sd5, 16'sd5, 16'sd5, 16'sd5, 16'sd5, 16'sd5,
                                  16'sd5, 16'sd5, 16'sd9, -16'sd9}));
    pending_q.push_back(query_t'({16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd100, 16'sd37,
                                  16'sd0, 16'sd0, 16'sd3, 16'sd7}));
    pending_q.push_back(query_t'({16'sd0, 16'sd0, 16'sd300, 16'sd100, 16'sd200, 16'sd400,
                                  -16'sd100, 16'sd300, 16'sd77, 16'sd13}));
    pending_q.push_back(query_t'({16'sd0, 16'sd0, -16'sd300, -16'sd100, -16'sd200, -16'sd400,
                                  16'sd100, -16'sd300, -16'sd77, -16'sd13}));
    for (int i = 0; i < 6; i++) pending_q.push_back(rect_query());
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    wait (pending_q.size() == 0);
    @(posedge clk_i);
    drain_pause <= 1'b1;
    wait (nearest_q.size() == 0);
    @(posedge clk_i);
    drain_pause <= 1'b0;
    for (int i = 0; i < 1030; i++) pending_q.push_back(rect_query());
    wait (pending_q.size() == 0);
    stim_done = 1'b1;
    wait (nearest_q.size() == 0);
    repeat (40) @(posedge clk_i);
    if (errors == 0 && nearest_q.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
